FILE: hdl/cmc_pkg.sv
// Shared types, codes and calendar helpers for the calendar minute counter.
// No dependencies; every other file of the block imports this package.
package cmc_pkg;

  localparam int unsigned InWidth  = 88;
  localparam int unsigned OutWidth = 56;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_COMPARE = 2'd2;

  localparam logic [1:0] ORD_EARLIER = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  localparam logic [15:0] YEAR_MIN = 16'd2000;
  localparam logic [15:0] YEAR_MAX = 16'd2099;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } cmc_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;    // request accepted, capture compare fields
    logic load;     // store the request's time fields
    logic advance;  // begin a multi-cycle advance
    logic step;     // add one minute
  } cmc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic adv_trivial;  // advance would change nothing
    logic last_step;    // this step is the final minute
  } cmc_sts_t;

  typedef struct packed {
    logic [1:0]  order;
    logic        valid;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] year;
  } cmc_res_t;

  // Days in a month; the month is assumed to be 1..12.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // Validity check. Inside 2000..2099 a year is leap exactly when it divides by 4.
  function automatic logic time_ok(input logic [15:0] y, input logic [7:0] mo,
                                   input logic [7:0] d, input logic [7:0] h,
                                   input logic [7:0] mi);
    logic ok;
    ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) && (mo >= 8'd1) && (mo <= 8'd12) &&
         (h <= 8'd23) && (mi <= 8'd59) && (d != 8'd0) &&
         (d <= {3'b000, month_days(mo[3:0], y[1:0] == 2'b00)});
    return ok;
  endfunction

endpackage

FILE: hdl/cmc_ctrl.sv
// Controller state machine of the calendar minute counter.
// Depends on cmc_pkg; drives the datapath and the output stage.
module cmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        action_i,
  input  logic              out_room_i,
  output logic              res_push_o,
  output cmc_pkg::cmc_cmd_t cmd_o,
  input  cmc_pkg::cmc_sts_t sts_i
);
  import cmc_pkg::*;

  cmc_state_e state_q, state_d;
  logic       accept;
  logic       is_adv;

  assign req_ready_o = (state_q == ST_IDLE) && out_room_i;
  assign accept      = req_valid_i && req_ready_o;
  assign is_adv      = (action_i == ACT_ADVANCE);

  assign cmd_o.start   = accept;
  assign cmd_o.load    = accept && (action_i == ACT_LOAD);
  assign cmd_o.advance = accept && is_adv && !sts_i.adv_trivial;
  assign cmd_o.step    = (state_q == ST_RUN);

  assign res_push_o = (accept && !(is_adv && !sts_i.adv_trivial)) ||
                      ((state_q == ST_RUN) && sts_i.last_step);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.advance) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.last_step) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !req_ready_o)
    else $error("request taken while an advance runs");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> out_room_i)
    else $error("result pushed without room in the output stage");

endmodule

FILE: hdl/cmc_dp.sv
// Datapath of the calendar minute counter: held time, minute stepper and result.
// Depends on cmc_pkg; commanded by cmc_ctrl.
module cmc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmc_pkg::cmc_cmd_t cmd_i,
  output cmc_pkg::cmc_sts_t sts_o,
  input  logic [15:0]       in_year_i,
  input  logic [7:0]        in_month_i,
  input  logic [7:0]        in_day_i,
  input  logic [7:0]        in_hour_i,
  input  logic [7:0]        in_minute_i,
  input  logic [31:0]       advance_count_i,
  output cmc_pkg::cmc_res_t res_o
);
  import cmc_pkg::*;

  logic [15:0] year_q, year_d;
  logic [7:0]  month_q, month_d, day_q, day_d, hour_q, hour_d, minute_q, minute_d;
  logic [31:0] count_q, count_d;
  logic [6:0]  c100_q, c100_d;   // year modulo 100 while advancing
  logic [8:0]  c400_q, c400_d;   // year modulo 400 while advancing
  logic [47:0] cmp_q, cmp_d;
  logic [6:0]  year_off;
  logic        leap;
  logic [4:0]  mlen;
  logic [47:0] held_d;

  assign year_off = 7'(year_q - YEAR_MIN);
  assign leap     = (c400_q[1:0] == 2'b00) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign mlen     = month_days(month_q[3:0], leap);

  assign sts_o.adv_trivial = !time_ok(year_q, month_q, day_q, hour_q, minute_q) ||
                             (advance_count_i == 32'd0);
  assign sts_o.last_step   = (count_q == 32'd1);

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    count_d  = count_q;
    c100_d   = c100_q;
    c400_d   = c400_q;
    if (cmd_i.load) begin
      year_d   = in_year_i;
      month_d  = in_month_i;
      day_d    = in_day_i;
      hour_d   = in_hour_i;
      minute_d = in_minute_i;
    end else if (cmd_i.advance) begin
      count_d = advance_count_i;
      c100_d  = year_off;
      c400_d  = {2'b00, year_off};
    end else if (cmd_i.step) begin
      count_d = count_q - 32'd1;
      if (minute_q != 8'd59) begin
        minute_d = minute_q + 8'd1;
      end else begin
        minute_d = 8'd0;
        if (hour_q != 8'd23) begin
          hour_d = hour_q + 8'd1;
        end else begin
          hour_d = 8'd0;
          if (day_q != {3'b000, mlen}) begin
            day_d = day_q + 8'd1;
          end else begin
            day_d = 8'd1;
            if (month_q != 8'd12) begin
              month_d = month_q + 8'd1;
            end else begin
              month_d = 8'd1;
              year_d  = year_q + 16'd1;
              c100_d  = (c100_q == 7'd99)  ? 7'd0 : c100_q + 7'd1;
              c400_d  = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
            end
          end
        end
      end
    end
  end

  assign cmp_d  = cmd_i.start ? {in_year_i, in_month_i, in_day_i, in_hour_i, in_minute_i}
                              : cmp_q;
  assign held_d = {year_d, month_d, day_d, hour_d, minute_d};

  // Field-by-field ordering equals an unsigned compare of the concatenation.
  always_comb begin
    res_o.year   = year_d;
    res_o.month  = month_d;
    res_o.day    = day_d;
    res_o.hour   = hour_d;
    res_o.minute = minute_d;
    res_o.valid  = time_ok(year_d, month_d, day_d, hour_d, minute_d);
    if (held_d < cmp_d) begin
      res_o.order = ORD_EARLIER;
    end else if (held_d > cmp_d) begin
      res_o.order = ORD_LATER;
    end else begin
      res_o.order = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= YEAR_MIN;
      month_q  <= 8'd1;
      day_q    <= 8'd1;
      hour_q   <= 8'd0;
      minute_q <= 8'd0;
      count_q  <= 32'd0;
      c100_q   <= 7'd0;
      c400_q   <= 9'd0;
    end else begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      count_q  <= count_d;
      c100_q   <= c100_d;
      c400_q   <= c400_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q <= cmp_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (count_q != 32'd0))
    else $error("minute step with no minutes left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (minute_q <= 8'd59) && (hour_q <= 8'd23) && (day_q != 8'd0))
    else $error("stepping an invalid held time");

endmodule

FILE: hdl/cmc_out.sv
// Two-entry output stage (result register plus skid register) of the counter.
// Depends on cmc_pkg for the result type.
module cmc_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmc_pkg::cmc_res_t res_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmc_pkg::cmc_res_t out_o
);
  import cmc_pkg::*;

  cmc_res_t out_q, skid_q;
  logic     out_v_q, skid_v_q;
  logic     free;

  assign room_o      = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
  assign free        = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (free) begin
      out_v_q  <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      out_q <= skid_v_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held while the output register is empty");

endmodule

FILE: hdl/calendar_minute_counter_unit.sv
// Top level of the calendar minute counter: stream ports, controller, datapath
// and output stage. Depends on cmc_pkg, cmc_ctrl, cmc_dp and cmc_out.
//
// Usage. Each request on the slave channel carries an action (load, advance
// by a count of minutes, or compare only; the unused code acts as compare)
// and a year-month-day-hour-minute time. Every request yields exactly one
// result on the master channel: the held time after the request, whether it
// is a valid Gregorian time in 2000..2099, and how it orders against the
// request's time fields.
// For load and compare the result is registered at once.
// An advance by N minutes walks the calendar one minute per cycle in the
// datapath's stepper: after the request is taken the stepper makes N steps
// and the slave channel stays held; the next request is taken after the last
// step. When N is zero or the held time is invalid, the advance is answered at once.
// The output has a result register and a skid register, so a request is
// still taken while one finished result waits on a stalled receiver; when
// both hold results, s_axis_tready drops until the receiver drains one.
// Reset sets the held time to 2000-01-01 00:00 and empties the output stage.
module calendar_minute_counter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // action[1:0], in_year[17:2], in_month[25:18], in_day[33:26], in_hour[41:34],
  // in_minute[49:42], advance_count[81:50], zero fill [87:82]
  input  logic [cmc_pkg::InWidth-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cur_year[15:0], cur_month[23:16], cur_day[31:24], cur_hour[39:32],
  // cur_minute[47:40], time_valid[48], order_result[50:49], zero fill [55:51]
  output logic [cmc_pkg::OutWidth-1:0]   m_axis_tdata
);
  import cmc_pkg::*;

  cmc_cmd_t cmd;
  cmc_sts_t sts;
  cmc_res_t res, out_res;
  logic     room;
  logic     push;

  // The controller decides when a request is taken and when a result is due.
  cmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .action_i    (s_axis_tdata[1:0]),
    .out_room_i  (room),
    .res_push_o  (push),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the time and forms the result from its next value.
  cmc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_year_i       (s_axis_tdata[17:2]),
    .in_month_i      (s_axis_tdata[25:18]),
    .in_day_i        (s_axis_tdata[33:26]),
    .in_hour_i       (s_axis_tdata[41:34]),
    .in_minute_i     (s_axis_tdata[49:42]),
    .advance_count_i (s_axis_tdata[81:50]),
    .res_o           (res)
  );

  // Results wait here for the receiver.
  cmc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {5'b00000, out_res.order, out_res.valid, out_res.minute,
                         out_res.hour, out_res.day, out_res.month, out_res.year};

endmodule
